/* hw/rtl/kcov_pkg.sv */
// ----------------------------------------------------------------------------
// K-bit code coverage monitor package
// Shared constants for the coverage monitor and its seen-map memory.
// ----------------------------------------------------------------------------
package kcov_pkg;

	// Default largest window length; the seen-map holds 2^MAX_WINDOW entries.
	localparam int MAX_WINDOW_DEF = 16;

	// Width of the window length register and of the remaining-codes port.
	localparam int WLEN_W  = 5;
	localparam int CODES_W = 17;

	// Width of the stream tag stored in each seen-map entry.
	localparam int EPOCH_W = 8;

	typedef logic [WLEN_W-1:0]  wlen_t;
	typedef logic [CODES_W-1:0] codes_t;
	typedef logic [EPOCH_W-1:0] epoch_t;

	localparam epoch_t EPOCH_NONE = '0;
	localparam epoch_t EPOCH_MAX  = '1;

endpackage

/* hw/rtl/kcov_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data held when idle.
// ----------------------------------------------------------------------------
module kcov_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hw/rtl/kbit_code_coverage_monitor_top.sv */
// ----------------------------------------------------------------------------
// K-bit code coverage monitor
// Tracks which K-bit codes have appeared in a sliding window of a bit stream.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) moves one item per stream bit:
//   bit_in and start_req. start_req marks the first bit of a new stream and
//   drops the window, bit count, seen codes and remaining count first.
//   The output channel (out_valid/out_ready) returns one item per input item:
//   window_full, codes_left and covered, in input order.
//   cfg_we/cfg_wdata set the window length K (0 reads as 1, above MAX_WINDOW
//   saturates); every write also restarts the stream. Write only while idle.
//   Throughput: one item per cycle while no sweep runs and the output does
//   not stall, set by the single read-modify-write of the seen-map memory,
//   with back-to-back hits on one code forwarded. Each taken item is loaded
//   into the read stage, then into the output register that drives out_valid.
//   When the receiver stalls, the result waits in the output register, one
//   more item waits in the read stage, and in_ready drops after that.
//   Reset: the seen-map is swept to zero, all 2^MAX_WINDOW entries
//   (65536 at the default), with in_ready low; config writes are still taken.
//   Each stream owns a tag; after 2^EPOCH_W-1 streams the tags run out and
//   the next restart waits for one more full sweep.
// ----------------------------------------------------------------------------
module kbit_code_coverage_monitor_top #(
	parameter int MAX_WINDOW = kcov_pkg::MAX_WINDOW_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  kcov_pkg::wlen_t      cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 bit_in,
	input  logic                 start_req,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 window_full,
	output kcov_pkg::codes_t     codes_left,
	output logic                 covered
);

	import kcov_pkg::*;

	localparam int AW    = MAX_WINDOW;
	localparam int DEPTH = 1 << MAX_WINDOW;
	localparam int KW    = $clog2(MAX_WINDOW + 1);
	localparam int CW    = MAX_WINDOW + 1;

	// Configuration and stream front state
	logic [KW-1:0] k_q;
	logic [AW-1:0] win_q;
	logic [KW-1:0] bits_q;
	logic [CW-1:0] count_q;
	epoch_t        epoch_q;

	// Clearing sweep
	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;

	// Read stage
	logic          s1_vld_q;
	logic          full_s1;
	logic          rst_s1;
	logic [AW-1:0] addr_s1;
	epoch_t        ep_s1;

	// Write that ran in the same cycle as the read now in the read stage
	logic          fwd_we_q;
	logic [AW-1:0] fwd_addr_q;
	epoch_t        fwd_ep_q;

	// Output register
	logic          out_vld_q;
	logic          full_q;
	logic [CW-1:0] left_q;

	logic          accept;
	logic          s1_adv;
	logic          sweep_req;
	logic [AW-1:0] mask;
	logic [AW-1:0] win_base;
	logic [AW-1:0] win_next;
	logic [KW-1:0] bits_base;
	logic [KW-1:0] bits_next;
	logic          full_next;
	logic [KW-1:0] k_new;
	logic [CW-1:0] pow2;
	logic [CW-1:0] pow2_new;
	epoch_t        rdata;
	logic          seen;
	logic [CW-1:0] cnt_base;
	logic          dec;
	logic [CW-1:0] cnt_new;
	logic          item_we;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	epoch_t        ram_wdata;

	// Active window length from the written value
	always_comb begin
		if (cfg_wdata == '0) begin
			k_new = KW'(1);
		end else if (32'(cfg_wdata) > MAX_WINDOW) begin
			k_new = KW'(MAX_WINDOW);
		end else begin
			k_new = KW'(cfg_wdata);
		end
	end

	assign pow2     = CW'(1) << k_q;
	assign pow2_new = CW'(1) << k_new;
	assign mask     = ~({AW{1'b1}} << k_q);

	// Shift the new bit in; a start drops the old window first
	assign win_base  = start_req ? '0 : win_q;
	assign win_next  = ({win_base[AW-2:0], bit_in} | AW'(0)) & mask;
	assign bits_base = start_req ? '0 : bits_q;
	assign bits_next = (bits_base < k_q) ? KW'(bits_base + 1'b1) : bits_base;
	assign full_next = (bits_next >= k_q);

	// Hold off a restart that would reuse a live tag until a sweep has run
	assign sweep_req = !clearing_q && in_valid && start_req && (epoch_q == EPOCH_MAX)
		&& !s1_vld_q;

	assign s1_adv   = s1_vld_q && (!out_vld_q || out_ready);
	assign in_ready = !clearing_q && (!s1_vld_q || s1_adv)
		&& !(start_req && (epoch_q == EPOCH_MAX));
	assign accept   = in_valid && in_ready;

	// Entry counts as seen if it carries this stream's tag, or was just written
	assign seen = (rdata == ep_s1)
		|| (fwd_we_q && (fwd_addr_q == addr_s1) && (fwd_ep_q == ep_s1));

	assign cnt_base = rst_s1 ? pow2 : count_q;
	assign dec      = full_s1 && !seen && (cnt_base != '0);
	assign cnt_new  = cnt_base - CW'(dec);
	assign item_we  = s1_adv && full_s1 && !seen;

	assign ram_we    = clearing_q ? 1'b1 : item_we;
	assign ram_waddr = clearing_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clearing_q ? EPOCH_NONE : ep_s1;

	kcov_ram #(
		.WIDTH(EPOCH_W),
		.DEPTH(DEPTH)
	) u_seen_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(win_next),
		.rdata(rdata)
	);

	// Front state: window, bit count, tag, sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q        <= KW'(1);
			win_q      <= '0;
			bits_q     <= '0;
			epoch_q    <= epoch_t'(1);
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == {AW{1'b1}}) begin
					clearing_q <= 1'b0;
				end
			end
			if (cfg_we) begin
				k_q    <= k_new;
				win_q  <= '0;
				bits_q <= '0;
				if (clearing_q || (epoch_q == EPOCH_MAX)) begin
					epoch_q <= epoch_t'(1);
					if (!clearing_q) begin
						clearing_q <= 1'b1;
						clr_addr_q <= '0;
					end
				end else begin
					epoch_q <= epoch_q + 1'b1;
				end
			end else if (sweep_req) begin
				// Tag wraps: the waiting start then takes tag one
				clearing_q <= 1'b1;
				clr_addr_q <= '0;
				epoch_q    <= EPOCH_NONE;
			end else if (accept) begin
				win_q  <= win_next;
				bits_q <= bits_next;
				if (start_req) begin
					epoch_q <= epoch_q + 1'b1;
				end
			end
		end
	end

	// Read stage and forwarding record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
			fwd_we_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_vld_q <= 1'b1;
				fwd_we_q <= item_we;
			end else if (s1_adv) begin
				s1_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			full_s1    <= full_next;
			rst_s1     <= start_req;
			addr_s1    <= win_next;
			ep_s1      <= start_req ? epoch_t'(epoch_q + 1'b1) : epoch_q;
			fwd_addr_q <= addr_s1;
			fwd_ep_q   <= ep_s1;
		end
	end

	// Remaining count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= CW'(2);
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				count_q <= pow2_new;
			end else if (s1_adv) begin
				count_q <= cnt_new;
			end
			if (s1_adv) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			full_q <= full_s1;
			left_q <= cnt_new;
		end
	end

	assign out_valid   = out_vld_q;
	assign window_full = full_q;
	assign codes_left  = codes_t'(left_q);
	assign covered     = (left_q == '0);

	// No item enters while the seen-map is being swept
	assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !in_ready)
		else $error("item taken during seen-map sweep");

	// Sweep and item writes never share the write port
	assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !s1_vld_q)
		else $error("read stage busy during seen-map sweep");

	// A live item never carries the empty tag
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_vld_q |-> (ep_s1 != EPOCH_NONE))
		else $error("item carries the cleared tag");

	// Full coverage is impossible before a whole window has arrived
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && covered) |-> window_full)
		else $error("covered without a full window");

	// Remaining count never exceeds the code space
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |-> (cnt_new <= pow2))
		else $error("remaining count above 2^K");

endmodule

/* bench/kbit_code_coverage_monitor_top_tb.sv */
// ----------------------------------------------------------------------------
// K-bit code coverage monitor testbench
// Streams bits through the monitor under several window lengths and handshake
// patterns. Every result is checked against a typed-in value or a bit-accurate
// software copy of the window, the seen-code set and the remaining-code count.
// ----------------------------------------------------------------------------
module kbit_code_coverage_monitor_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kcov_pkg::*;

	localparam int MAX_WIN = MAX_WINDOW_DEF;
	// The reset sweep clears all 2^MAX_WIN entries; a second sweep can follow
	// if the stream tags run out. About 600 items with worst gaps, stalls and
	// one long hold-off stay far below this limit.
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS = 92;
	localparam int HOLD_CYCLES = 300;
	localparam int SHOW_LIMIT = 10;

	typedef struct packed {
		logic   full;
		codes_t left;
		logic   cov;
	} cov_result_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	// One directed row: either a window length write or one stream bit, with
	// an optional typed-in expectation.
	typedef struct packed {
		row_kind_t   kind;
		wlen_t       wlen;
		logic        bit_val;
		logic        start;
		logic        typed;
		cov_result_t want;
	} dir_row_t;

	localparam int DIR_ROWS = 26;
	localparam codes_t ALL16 = 17'd65536;

	// Short streams, coverage at K=1 and K=2, bits after coverage, restarts
	// by start flag and by register write, and the length extremes 0, 31, 17.
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_ITEM, 5'd0,  1'b0, 1'b0, 1'b1, '{1'b1, 17'd1, 1'b0}},
		'{ROW_ITEM, 5'd0,  1'b0, 1'b0, 1'b1, '{1'b1, 17'd1, 1'b0}},
		'{ROW_ITEM, 5'd0,  1'b1, 1'b0, 1'b1, '{1'b1, 17'd0, 1'b1}},
		'{ROW_ITEM, 5'd0,  1'b0, 1'b0, 1'b1, '{1'b1, 17'd0, 1'b1}},
		'{ROW_CFG,  5'd2,  1'b0, 1'b0, 1'b0, '0},
		'{ROW_ITEM, 5'd0,  1'b1, 1'b0, 1'b1, '{1'b0, 17'd4, 1'b0}},
		'{ROW_ITEM, 5'd0,  1'b1, 1'b0, 1'b1, '{1'b1, 17'd3, 1'b0}},
		'{ROW_ITEM, 5'd0,  1'b0, 1'b0, 1'b0, '0},
		'{ROW_ITEM, 5'd0,  1'b0, 1'b0, 1'b0, '0},
		'{ROW_ITEM, 5'd0,  1'b1, 1'b0, 1'b1, '{1'b1, 17'd0, 1'b1}},
		'{ROW_ITEM, 5'd0,  1'b1, 1'b1, 1'b1, '{1'b0, 17'd4, 1'b0}},
		'{ROW_ITEM, 5'd0,  1'b0, 1'b0, 1'b0, '0},
		'{ROW_CFG,  5'd0,  1'b0, 1'b0, 1'b0, '0},
		'{ROW_ITEM, 5'd0,  1'b1, 1'b0, 1'b1, '{1'b1, 17'd1, 1'b0}},
		'{ROW_ITEM, 5'd0,  1'b1, 1'b1, 1'b1, '{1'b1, 17'd1, 1'b0}},
		'{ROW_CFG,  5'd31, 1'b0, 1'b0, 1'b0, '0},
		'{ROW_ITEM, 5'd0,  1'b1, 1'b0, 1'b1, '{1'b0, ALL16, 1'b0}},
		'{ROW_ITEM, 5'd0,  1'b0, 1'b0, 1'b0, '0},
		'{ROW_CFG,  5'd17, 1'b0, 1'b0, 1'b0, '0},
		'{ROW_ITEM, 5'd0,  1'b1, 1'b1, 1'b1, '{1'b0, ALL16, 1'b0}},
		'{ROW_CFG,  5'd16, 1'b0, 1'b0, 1'b0, '0},
		'{ROW_ITEM, 5'd0,  1'b0, 1'b0, 1'b1, '{1'b0, ALL16, 1'b0}},
		'{ROW_CFG,  5'd1,  1'b0, 1'b0, 1'b0, '0},
		'{ROW_ITEM, 5'd0,  1'b0, 1'b1, 1'b1, '{1'b1, 17'd1, 1'b0}},
		'{ROW_ITEM, 5'd0,  1'b1, 1'b0, 1'b1, '{1'b1, 17'd0, 1'b1}},
		'{ROW_ITEM, 5'd0,  1'b1, 1'b1, 1'b1, '{1'b1, 17'd1, 1'b0}}
	};

	// Window lengths of the random phases; 0 exercises the K=1 fallback.
	wlen_t phase_len [RANDOM_PHASES] = '{5'd3, 5'd4, 5'd2, 5'd5, 5'd0, 5'd16};
	// Idle patterns: none, sender 81, receiver 81, both 25, none with a long
	// receiver hold-off, sender 81 again.
	int phase_send_idle [RANDOM_PHASES] = '{0, 81, 0, 25, 0, 81};
	int phase_stall [RANDOM_PHASES] = '{0, 0, 81, 25, 0, 0};
	localparam int PRESSURE_PHASE = 4;

	// DUT ports; every input holds a known value from time zero.
	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   cfg_we = 1'b0;
	wlen_t  cfg_wdata = '0;
	logic   in_valid = 1'b0;
	logic   in_ready;
	logic   bit_in = 1'b0;
	logic   start_req = 1'b0;
	logic   out_valid;
	logic   out_ready = 1'b0;
	logic   window_full;
	codes_t codes_left;
	logic   covered;

	// Software copy of the monitor state.
	wlen_t       cur_len;
	logic [15:0] win_bits;
	int unsigned bits_got;
	codes_t      codes_rem;
	bit          seen_codes [logic [15:0]];

	cov_result_t coverage_due [$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_reqs = 0;
	int unsigned cycles = 0;
	int items_sent = 0;
	int results_seen = 0;
	int covered_seen = 0;
	int streams_begun = 0;
	int mismatches = 0;
	int errors = 0;

	kbit_code_coverage_monitor_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.bit_in     (bit_in),
		.start_req  (start_req),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.window_full(window_full),
		.codes_left (codes_left),
		.covered    (covered)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still due", cycles,
				coverage_due.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Effective window length: zero reads as one, large values saturate.
	function automatic int unsigned active_len();
		int unsigned k;
		k = 32'(cur_len);
		if (k == 0)
			k = 1;
		if (k > MAX_WIN)
			k = MAX_WIN;
		return k;
	endfunction

	// Drop window, bit count and seen codes; all 2^K codes are due again.
	function automatic void restart_model();
		win_bits = '0;
		bits_got = 0;
		codes_rem = codes_t'(1) << active_len();
		seen_codes.delete();
		streams_begun++;
	endfunction

	// Advance the software copy by one bit and return the result it owes.
	function automatic cov_result_t predict_coverage(logic b, logic s);
		int unsigned k;
		logic [15:0] mask;
		cov_result_t r;
		if (s)
			restart_model();
		k = active_len();
		mask = 16'((32'd1 << k) - 1);
		win_bits = ((win_bits << 1) | 16'(b)) & mask;
		if (bits_got < k)
			bits_got++;
		r.full = (bits_got >= k);
		if (r.full && !seen_codes.exists(win_bits)) begin
			seen_codes[win_bits] = 1'b1;
			if (codes_rem != 0)
				codes_rem--;
		end
		r.left = codes_rem;
		r.cov = (codes_rem == 0);
		return r;
	endfunction

	// Offer one item and hold it until taken; log what it must produce.
	// Entered and left at a rising edge. typed selects a typed-in result.
	task automatic push_bit(logic b, logic s, logic typed, cov_result_t want);
		cov_result_t r;
		in_valid <= 1'b1;
		bit_in <= b;
		start_req <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = predict_coverage(b, s);
		coverage_due.push_back(typed ? want : r);
		items_sent++;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// Drain, then write the window length; the write restarts the stream.
	task automatic write_window_len(wlen_t v);
		in_valid <= 1'b0;
		while (coverage_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_len = v;
		restart_model();
	endtask

	// Receiver: random stalls per phase, plus a long hold-off on request.
	initial begin
		int hold_left;
		int hold_taken;
		hold_left = 0;
		hold_taken = 0;
		forever begin
			@(posedge clk);
			if (hold_reqs != hold_taken) begin
				hold_taken = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Compare each delivered item with the oldest result still due.
	always @(posedge clk) begin
		cov_result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (covered === 1'b1)
				covered_seen++;
			if (coverage_due.size() == 0) begin
				errors++;
				mismatches++;
				if (mismatches <= SHOW_LIMIT)
					$display("%0t: unexpected item full=%b left=%0d covered=%b", $realtime,
						window_full, codes_left, covered);
			end else begin
				want = coverage_due.pop_front();
				if (window_full !== want.full || codes_left !== want.left ||
					covered !== want.cov) begin
					errors++;
					mismatches++;
					if (mismatches <= SHOW_LIMIT)
						$display("%0t: item %0d: full %b/%b left %0d/%0d covered %b/%b (exp/got)",
							$realtime, results_seen - 1, want.full, window_full, want.left,
							codes_left, want.cov, covered);
				end
			end
		end
	end

	// Main sequence: reset, directed table, random phases, drain, verdict.
	initial begin
		int k;
		int sent;
		int len;
		int cap;
		cur_len = 5'd1;
		restart_model();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: walk the table, no idling on either side.
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].kind == ROW_CFG)
				write_window_len(dir_rows[i].wlen);
			else
				push_bit(dir_rows[i].bit_val, dir_rows[i].start, dir_rows[i].typed,
					dir_rows[i].want);
		end

		// Random part: mostly well-formed streams that start with the start
		// flag and can run long enough to cover small windows, mixed with noise
		// bursts that may restart mid-stream at random.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_window_len(phase_len[p]);
			send_idle_pct = phase_send_idle[p];
			stall_pct = phase_stall[p];
			// Hold the receiver off while the sender keeps offering, so the
			// pipeline fills and in_ready drops.
			if (p == PRESSURE_PHASE)
				hold_reqs <= hold_reqs + 1;
			k = active_len();
			cap = (k <= 5) ? k + (4 << k) : k + 48;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(99) < 85) begin
					len = $urandom_range(1, cap);
					if (len > PHASE_ITEMS - sent)
						len = PHASE_ITEMS - sent;
					for (int j = 0; j < len; j++)
						push_bit(1'($urandom_range(1)), j == 0, 1'b0, '0);
				end else begin
					len = $urandom_range(1, 8);
					if (len > PHASE_ITEMS - sent)
						len = PHASE_ITEMS - sent;
					for (int j = 0; j < len; j++)
						push_bit(1'($urandom_range(1)), $urandom_range(9) == 0, 1'b0, '0);
				end
				sent += len;
			end
		end

		// Drain, then keep watching the output so that stray items show.
		in_valid <= 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		while (coverage_due.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		errors += coverage_due.size();

		$display("Ran %0d bits in %0d streams over window lengths 0..31 and 6 idle patterns;",
			items_sent, streams_begun);
		$display("%0d results checked, %0d of them fully covered, %0d mismatches.",
			results_seen, covered_seen, mismatches);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
